// ===== rtl/core/dmcm_pkg.sv =====
// ----------------------------------------------------------------------------
// dmcm_pkg
// Shared types, widths and codes of the door motor current monitor.
// ----------------------------------------------------------------------------
package dmcm_pkg;

	// ADC sample width
	localparam int SAMPLE_BITS = 12;

	localparam int LIM_W   = 12;  // limit and zero current
	localparam int FACT_W  = 4;   // overload factor
	localparam int DRIFT_W = 10;  // quiet drift
	localparam int CNT_W   = 16;  // leaky counters and their end counts
	localparam int CFG_W   = 16;  // widest configuration register
	localparam int IDX_W   = 3;   // configuration register index

	// signed excess of a sample over the limit current
	localparam int EXC_W = ((SAMPLE_BITS > LIM_W) ? SAMPLE_BITS : LIM_W) + 1;
	// overload level, limit times factor
	localparam int OVL_W = LIM_W + FACT_W;
	// quiet level, zero current plus drift
	localparam int QL_W  = LIM_W + 1;
	// signed compare width that holds all of the above
	localparam int CMP_W = (EXC_W > OVL_W + 1) ? EXC_W : OVL_W + 1;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_CLOSE  = 2'd1,
		FUNC_OPEN   = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_CLOSE = 2'd1,
		MODE_OPEN  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_RUN      = 2'd1,
		ST_DONE     = 2'd2,
		ST_OVERLOAD = 2'd3
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		CFG_LIMIT_CURRENT  = 3'd0,
		CFG_ZERO_CURRENT   = 3'd1,
		CFG_OVERLOAD_FACT  = 3'd2,
		CFG_CLOSE_DRIFT    = 3'd3,
		CFG_OPEN_DRIFT     = 3'd4,
		CFG_OVERLOAD_STOP  = 3'd5,
		CFG_QUIET_FINISH   = 3'd6
	} cfg_idx_t;

	// compare outcome of one sample
	typedef struct packed {
		logic over;
		logic quiet;
	} cmp_flags_t;

	// result of one step
	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] ovl_cnt;
	} step_res_t;

endpackage

// ===== rtl/core/dmcm_if.sv =====
// ----------------------------------------------------------------------------
// dmcm_in_if / dmcm_out_if
// Valid/ready channels carrying commands and samples in, status out.
// ----------------------------------------------------------------------------
interface dmcm_in_if;
	logic                              valid;
	logic                              ready;
	dmcm_pkg::func_t                   func;
	logic [dmcm_pkg::SAMPLE_BITS-1:0]  current_sample;

	modport source (output valid, output func, output current_sample, input ready);
	modport sink   (input valid, input func, input current_sample, output ready);
endinterface

interface dmcm_out_if;
	logic                         valid;
	logic                         ready;
	dmcm_pkg::status_t            status;
	logic [dmcm_pkg::CNT_W-1:0]   overload_level_count;

	modport source (output valid, output status, output overload_level_count, input ready);
	modport sink   (input valid, input status, input overload_level_count, output ready);
endinterface

// ===== rtl/core/dmcm_eval.sv =====
// ----------------------------------------------------------------------------
// dmcm_eval
// Excess of a sample and its compare against overload and quiet levels.
// ----------------------------------------------------------------------------
module dmcm_eval (
	input  dmcm_pkg::mode_t                       mode,
	input  logic [dmcm_pkg::SAMPLE_BITS-1:0]      sample,
	input  logic signed [dmcm_pkg::EXC_W-1:0]     prev_excess,
	input  logic [dmcm_pkg::LIM_W-1:0]            limit_current,
	input  logic [dmcm_pkg::LIM_W-1:0]            idle_current,
	input  logic [dmcm_pkg::FACT_W-1:0]           overload_factor,
	input  logic [dmcm_pkg::DRIFT_W-1:0]          close_drift,
	input  logic [dmcm_pkg::DRIFT_W-1:0]          open_drift,
	output logic signed [dmcm_pkg::EXC_W-1:0]     excess,
	output dmcm_pkg::cmp_flags_t                  flags
);
	import dmcm_pkg::*;

	logic [OVL_W-1:0]         ovl_lvl;
	logic [DRIFT_W-1:0]       drift;
	logic [QL_W-1:0]          quiet_lvl;
	logic signed [CMP_W-1:0]  exc_c;
	logic signed [CMP_W-1:0]  prev_c;
	logic signed [CMP_W-1:0]  ovl_c;
	logic signed [CMP_W-1:0]  quiet_c;

	assign excess    = $signed(EXC_W'(sample)) - $signed(EXC_W'(limit_current));
	assign ovl_lvl   = OVL_W'(limit_current) * OVL_W'(overload_factor);
	assign drift     = (mode == MODE_OPEN) ? open_drift : close_drift;
	assign quiet_lvl = QL_W'(idle_current) + QL_W'(drift);

	assign exc_c   = CMP_W'(excess);
	assign prev_c  = CMP_W'(prev_excess);
	assign ovl_c   = $signed(CMP_W'(ovl_lvl));
	assign quiet_c = $signed(CMP_W'(quiet_lvl));

	// both this and the previous excess must agree
	assign flags.over  = (exc_c > ovl_c) && (prev_c > ovl_c);
	assign flags.quiet = (exc_c < quiet_c) && (prev_c < quiet_c);

endmodule

// ===== rtl/core/dmcm_track.sv =====
// ----------------------------------------------------------------------------
// dmcm_track
// Move mode, previous excess and leaky counters; end-of-move decision.
// ----------------------------------------------------------------------------
module dmcm_track (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  dmcm_pkg::func_t                       func,
	input  logic signed [dmcm_pkg::EXC_W-1:0]     excess,
	input  dmcm_pkg::cmp_flags_t                  flags,
	input  logic [dmcm_pkg::CNT_W-1:0]            overload_stop_count,
	input  logic [dmcm_pkg::CNT_W-1:0]            quiet_finish_count,
	output dmcm_pkg::mode_t                       mode_q,
	output logic signed [dmcm_pkg::EXC_W-1:0]     prev_excess_q,
	output dmcm_pkg::step_res_t                   res
);
	import dmcm_pkg::*;

	logic [CNT_W-1:0]         ovl_cnt_q, quiet_cnt_q;
	logic [CNT_W-1:0]         ovl_up, ovl_dn, quiet_up, quiet_dn;
	logic [CNT_W-1:0]         ovl_upd, quiet_upd;
	logic [CNT_W-1:0]         ovl_cnt_d, quiet_cnt_d;
	logic signed [EXC_W-1:0]  prev_excess_d;
	mode_t                    mode_d;
	logic                     stop_hit, finish_hit;

	assign ovl_up   = (ovl_cnt_q == CNT_MAX) ? CNT_MAX : ovl_cnt_q + CNT_W'(1);
	assign ovl_dn   = (ovl_cnt_q == '0) ? '0 : ovl_cnt_q - CNT_W'(1);
	assign quiet_up = (quiet_cnt_q == CNT_MAX) ? CNT_MAX : quiet_cnt_q + CNT_W'(1);
	assign quiet_dn = (quiet_cnt_q == '0) ? '0 : quiet_cnt_q - CNT_W'(1);

	// counter update for a sample inside a move
	always_comb begin
		if (mode_q == MODE_CLOSE) begin
			if (flags.over) begin
				ovl_upd   = ovl_up;
				quiet_upd = quiet_dn;
			end else if (flags.quiet) begin
				ovl_upd   = ovl_dn;
				quiet_upd = quiet_up;
			end else begin
				ovl_upd   = ovl_dn;
				quiet_upd = quiet_dn;
			end
		end else begin
			ovl_upd   = ovl_cnt_q;
			quiet_upd = flags.quiet ? quiet_up : quiet_dn;
		end
	end

	assign stop_hit   = (mode_q == MODE_CLOSE) && (ovl_upd >= overload_stop_count);
	assign finish_hit = quiet_upd >= quiet_finish_count;

	// next state
	always_comb begin
		mode_d        = mode_q;
		prev_excess_d = prev_excess_q;
		ovl_cnt_d     = ovl_cnt_q;
		quiet_cnt_d   = quiet_cnt_q;
		unique case (func)
			FUNC_CLOSE, FUNC_OPEN: begin
				mode_d        = (func == FUNC_CLOSE) ? MODE_CLOSE : MODE_OPEN;
				prev_excess_d = '0;
				ovl_cnt_d     = '0;
				quiet_cnt_d   = '0;
			end
			FUNC_SAMPLE: begin
				if (mode_q != MODE_IDLE) begin
					ovl_cnt_d   = ovl_upd;
					quiet_cnt_d = quiet_upd;
					if (stop_hit || finish_hit) begin
						mode_d = MODE_IDLE;
					end else begin
						prev_excess_d = excess;
					end
				end
			end
			default: ;
		endcase
	end

	// step result
	always_comb begin
		res.status  = ST_IDLE;
		res.ovl_cnt = ovl_cnt_d;
		unique case (func)
			FUNC_CLOSE, FUNC_OPEN: res.status = ST_RUN;
			FUNC_SAMPLE: begin
				if (mode_q != MODE_IDLE) begin
					if (stop_hit) begin
						res.status = ST_OVERLOAD;
					end else if (finish_hit) begin
						res.status = ST_DONE;
					end else begin
						res.status = ST_RUN;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			prev_excess_q <= '0;
			ovl_cnt_q     <= '0;
			quiet_cnt_q   <= '0;
		end else if (adv) begin
			mode_q        <= mode_d;
			prev_excess_q <= prev_excess_d;
			ovl_cnt_q     <= ovl_cnt_d;
			quiet_cnt_q   <= quiet_cnt_d;
		end
	end

endmodule

// ===== rtl/core/door_motor_current_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// door_motor_current_monitor_unit
// Current watch for one door motor move: overload stop and normal finish.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake       | payload
//  ----------+-----+-----------------+------------------------------------------
//  in_ch     | in  | valid / ready   | func, current_sample
//  out_ch    | out | valid / ready   | status, overload_level_count
//  cfg       | in  | cfg_we          | cfg_idx, cfg_wdata (write only)
//
//  One transaction in gives one transaction out. A transaction enters the
//  input stage (_s1), is evaluated there against the move state, and its
//  result lands in the output register. Throughput is one transaction per
//  cycle while out_ch does not stall. The input stage keeps taking a
//  transaction while a result waits on out_ch; it holds once both the stage
//  and the output register are full.
//  arst_n clears move state, valid flags and loads register defaults.
//
module door_motor_current_monitor_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	dmcm_in_if.sink                           in_ch,
	dmcm_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [dmcm_pkg::IDX_W-1:0]        cfg_idx,
	input  logic [dmcm_pkg::CFG_W-1:0]        cfg_wdata
);
	import dmcm_pkg::*;

	// configuration registers
	logic [LIM_W-1:0]    limit_current_q;
	logic [LIM_W-1:0]    idle_current_q;
	logic [FACT_W-1:0]   overload_factor_q;
	logic [DRIFT_W-1:0]  close_drift_q;
	logic [DRIFT_W-1:0]  open_drift_q;
	logic [CNT_W-1:0]    overload_stop_q;
	logic [CNT_W-1:0]    quiet_finish_q;

	// input stage
	logic                    valid_s1;
	func_t                   func_s1;
	logic [SAMPLE_BITS-1:0]  sample_s1;
	logic                    adv_s1;

	// output register
	logic                    out_valid_q;
	step_res_t               out_res_q;

	// evaluation
	mode_t                   mode;
	logic signed [EXC_W-1:0] prev_excess;
	logic signed [EXC_W-1:0] excess;
	cmp_flags_t              flags;
	step_res_t               res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_current_q   <= '0;
			idle_current_q    <= '0;
			overload_factor_q <= FACT_W'(1);
			close_drift_q     <= '0;
			open_drift_q      <= '0;
			overload_stop_q   <= CNT_W'(10);
			quiet_finish_q    <= CNT_W'(10);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LIMIT_CURRENT: limit_current_q   <= cfg_wdata[LIM_W-1:0];
				CFG_ZERO_CURRENT:  idle_current_q    <= cfg_wdata[LIM_W-1:0];
				CFG_OVERLOAD_FACT: overload_factor_q <= cfg_wdata[FACT_W-1:0];
				CFG_CLOSE_DRIFT:   close_drift_q     <= cfg_wdata[DRIFT_W-1:0];
				CFG_OPEN_DRIFT:    open_drift_q      <= cfg_wdata[DRIFT_W-1:0];
				CFG_OVERLOAD_STOP: overload_stop_q   <= cfg_wdata[CNT_W-1:0];
				CFG_QUIET_FINISH:  quiet_finish_q    <= cfg_wdata[CNT_W-1:0];
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// Advance the input stage when the output register is free or drains now.
	assign adv_s1      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// payload: load on every accepted transaction, hold otherwise
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			func_s1   <= in_ch.func;
			sample_s1 <= in_ch.current_sample;
		end
	end

	dmcm_eval u_eval (
		.mode            (mode),
		.sample          (sample_s1),
		.prev_excess     (prev_excess),
		.limit_current   (limit_current_q),
		.idle_current    (idle_current_q),
		.overload_factor (overload_factor_q),
		.close_drift     (close_drift_q),
		.open_drift      (open_drift_q),
		.excess          (excess),
		.flags           (flags)
	);

	// move state advances exactly once per transaction leaving the input stage
	dmcm_track u_track (
		.clk                 (clk),
		.arst_n              (arst_n),
		.adv                 (adv_s1),
		.func                (func_s1),
		.excess              (excess),
		.flags               (flags),
		.overload_stop_count (overload_stop_q),
		.quiet_finish_count  (quiet_finish_q),
		.mode_q              (mode),
		.prev_excess_q       (prev_excess),
		.res                 (res)
	);

	// Output register: load on advance, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_res_q <= res;
		end
	end

	assign out_ch.valid                = out_valid_q;
	assign out_ch.status               = out_res_q.status;
	assign out_ch.overload_level_count = out_res_q.ovl_cnt;

	// A start command always reports a running move with a cleared counter.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (func_s1 == FUNC_CLOSE || func_s1 == FUNC_OPEN)
		|=> out_valid_q && out_res_q.status == ST_RUN && out_res_q.ovl_cnt == '0)
		else $error("start command did not report a fresh running move");

	// A finished or stopped move leaves the block idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (res.status == ST_DONE || res.status == ST_OVERLOAD)
		|=> mode == MODE_IDLE)
		else $error("move still active after an end status");

	// An overload stop only ever comes out of a close move.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res.status == ST_OVERLOAD |-> mode == MODE_CLOSE)
		else $error("overload stop outside a close move");

	// Move state holds while the input stage is stalled or empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> mode == $past(mode) && prev_excess == $past(prev_excess))
		else $error("move state changed without a transaction");

endmodule
